[hw/rtl/lhd_pkg.sv]
// ---------------------------------------------------------------------------
// lhd_pkg
// Shared types and constants for the line hash diff engine.
// ---------------------------------------------------------------------------
package lhd_pkg;

   // command codes on the request channel
   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_EOL   = 2'd1,
      CMD_FETCH = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // entry kinds on the response channel
   localparam logic [1:0] KIND_COMMON = 2'd0;
   localparam logic [1:0] KIND_FIRST  = 2'd1;
   localparam logic [1:0] KIND_SECOND = 2'd2;

   localparam int unsigned HASH_W    = 32;
   localparam int unsigned LINE_W    = 10;
   localparam logic [31:0] HASH_SEED = 32'd5137;
   localparam logic [4:0]  HASH_SHIFT = 5'd5;
   localparam logic [7:0]  WS_LIMIT  = 8'd32;

   // one queued request
   typedef struct packed {
      cmd_type    cmd;
      logic       file_select;
      logic [7:0] char_byte;
   } req_item_type;

   // one response item
   typedef struct packed {
      logic              entry_valid;
      logic              entry_file;
      logic [LINE_W-1:0] entry_line;
      logic [1:0]        entry_kind;
      logic              bookmark_before;
      logic              last_entry;
      logic              files_differ;
      logic              overflow;
   } rsp_item_type;

endpackage

[hw/rtl/lhd_ram.sv]
// ---------------------------------------------------------------------------
// lhd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module lhd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lhd_front.sv]
// ---------------------------------------------------------------------------
// lhd_front
// Request intake: decodes each transfer into a command item and holds it in
// a short queue so the engine can stall on its own.
// ---------------------------------------------------------------------------
module lhd_front
   import lhd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_command,
   input  logic         req_file_select,
   input  logic [7:0]   req_char_byte,
   output logic         q_valid,
   output req_item_type q_item,
   input  logic         q_pop
);

   localparam int unsigned QD = 4;
   localparam int unsigned QA = $clog2(QD);

   req_item_type     q_mem [QD];
   logic [QA-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QA-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QA:0]      fill_ff, fill_in;
   logic             push;
   req_item_type     new_item;

   // classify the incoming transfer
   always_comb begin
      new_item.cmd         = cmd_type'(req_command);
      new_item.file_select = req_file_select;
      new_item.char_byte   = req_char_byte;
   end

   assign req_stall = (fill_ff == (QA+1)'(QD));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = q_mem[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QA+1)'(push) - (QA+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[hw/rtl/lhd_engine.sv]
// ---------------------------------------------------------------------------
// lhd_engine
// Back end: line hashing, hash storage, merge sequencing and the two greedy
// resync searches, with a registered response slot.
// ---------------------------------------------------------------------------
module lhd_engine
   import lhd_pkg::*;
#(
   parameter int unsigned MAX_LINES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         skip_ws,
   input  logic         q_valid,
   input  req_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int unsigned CW = $clog2(MAX_LINES + 1);
   localparam int unsigned AW = $clog2(MAX_LINES);

   typedef enum logic [4:0] {
      PH_LOADING = 5'b00001,
      PH_DECIDE  = 5'b00010,
      PH_DIFF1   = 5'b00100,
      PH_DIFF2   = 5'b01000,
      PH_DONE    = 5'b10000
   } phase_type;

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_STEP    = 12'b000000000010,
      ST_CHK_RD  = 12'b000000000100,
      ST_CHK_CMP = 12'b000000001000,
      ST_S_INIT  = 12'b000000010000,
      ST_S_J     = 12'b000000100000,
      ST_S_I     = 12'b000001000000,
      ST_RL_RD   = 12'b000010000000,
      ST_RL_CMP  = 12'b000100000000,
      ST_RL_DONE = 12'b001000000000,
      ST_S_NEXTJ = 12'b010000000000,
      ST_S_END   = 12'b100000000000
   } state_type;

   state_type           st_ff, st_in;
   phase_type           phase_ff, phase_in;
   logic [HASH_W-1:0]   hash_ff [2], hash_in [2];
   logic [CW-1:0]       cnt_ff [2], cnt_in [2];
   logic [CW-1:0]       pos_ff [2], pos_in [2];
   logic [CW-1:0]       tgt_ff [2], tgt_in [2];
   logic                differ_ff, differ_in;
   logic                ovf_ff, ovf_in;
   logic                bm_ff, bm_in;

   // search registers
   logic                outer_ff, outer_in;
   logic [CW-1:0]       j_ff, j_in, i_ff, i_in, stop_ff, stop_in;
   logic [CW-1:0]       best_ff, best_in, at1_ff, at1_in, at2_ff, at2_in;
   logic [CW-1:0]       m1_ff, m1_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [CW-1:0]       rl_a_ff, rl_a_in, rl_b_ff, rl_b_in, rl_m_ff, rl_m_in;

   // response slot
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   // memory ports
   logic                we0, we1;
   logic [AW-1:0]       waddr;
   logic [HASH_W-1:0]   rd0, rd1;

   logic                rsp_free;
   logic                f;
   logic                inner;
   logic [CW-1:0]       hi;
   logic [CW:0]         hi_sum;
   logic [CW:0]         jb_sum;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign inner     = ~outer_ff;

   lhd_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LINES)) u_first_ram (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (waddr),
      .wr_data (hash_ff[0]),
      .rd_addr (rl_a_ff[AW-1:0]),
      .rd_data (rd0)
   );

   lhd_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LINES)) u_second_ram (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (waddr),
      .wr_data (hash_ff[1]),
      .rd_addr (rl_b_ff[AW-1:0]),
      .rd_data (rd1)
   );

   // sequencer
   always_comb begin
      st_in        = st_ff;
      phase_in     = phase_ff;
      hash_in      = hash_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      tgt_in       = tgt_ff;
      differ_in    = differ_ff;
      ovf_in       = ovf_ff;
      bm_in        = bm_ff;
      outer_in     = outer_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      stop_in      = stop_ff;
      best_in      = best_ff;
      at1_in       = at1_ff;
      at2_in       = at2_ff;
      m1_in        = m1_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      rl_a_in      = rl_a_ff;
      rl_b_in      = rl_b_ff;
      rl_m_in      = rl_m_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      we0          = 1'b0;
      we1          = 1'b0;
      f            = q_item.file_select;
      waddr        = cnt_ff[q_item.file_select][AW-1:0];
      hi           = (i_ff > j_ff) ? i_ff : j_ff;
      hi_sum       = {1'b0, hi} + {1'b0, rl_m_ff};
      jb_sum       = {1'b0, j_ff} + {1'b0, best_ff};

      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.cmd)
                  CMD_CLEAR: begin
                     hash_in[0] = HASH_SEED;
                     hash_in[1] = HASH_SEED;
                     cnt_in[0]  = '0;
                     cnt_in[1]  = '0;
                     pos_in[0]  = '0;
                     pos_in[1]  = '0;
                     tgt_in[0]  = '0;
                     tgt_in[1]  = '0;
                     phase_in   = PH_LOADING;
                     differ_in  = 1'b0;
                     ovf_in     = 1'b0;
                     bm_in      = 1'b0;
                     q_pop      = 1'b1;
                  end
                  CMD_PUSH: begin
                     if (phase_ff == PH_LOADING &&
                         !(skip_ws && q_item.char_byte <= WS_LIMIT)) begin
                        hash_in[f] = (hash_ff[f] << HASH_SHIFT) + hash_ff[f] +
                                     HASH_W'(q_item.char_byte);
                     end
                     q_pop = 1'b1;
                  end
                  CMD_EOL: begin
                     if (phase_ff == PH_LOADING) begin
                        if (cnt_ff[f] < CW'(MAX_LINES)) begin
                           we0       = !f;
                           we1       = f;
                           cnt_in[f] = cnt_ff[f] + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                        hash_in[f] = HASH_SEED;
                     end
                     q_pop = 1'b1;
                  end
                  CMD_FETCH: begin
                     if (phase_ff == PH_LOADING) begin
                        phase_in = PH_DECIDE;
                     end
                     st_in = ST_STEP;
                  end
                  default: ;
               endcase
            end
         end

         // one merge decision per cycle, held while the response slot is busy
         ST_STEP: begin
            f = (phase_ff == PH_DIFF2);
            if (phase_ff == PH_DECIDE) begin
               if (pos_ff[0] >= cnt_ff[0] && pos_ff[1] >= cnt_ff[1]) begin
                  phase_in = PH_DONE;
               end else if (pos_ff[0] >= cnt_ff[0] || pos_ff[1] >= cnt_ff[1]) begin
                  tgt_in   = cnt_ff;
                  phase_in = PH_DIFF1;
                  bm_in    = 1'b1;
               end else begin
                  rl_a_in = pos_ff[0];
                  rl_b_in = pos_ff[1];
                  st_in   = ST_CHK_RD;
               end
            end else if (phase_ff == PH_DIFF1 || phase_ff == PH_DIFF2) begin
               if (pos_ff[f] < tgt_ff[f]) begin
                  if (rsp_free) begin
                     pos_in[f]              = pos_ff[f] + 1'b1;
                     bm_in                  = 1'b0;
                     differ_in              = 1'b1;
                     rsp_valid_in           = 1'b1;
                     rsp_in.entry_valid     = 1'b1;
                     rsp_in.entry_file      = f;
                     rsp_in.entry_line      = LINE_W'(pos_ff[f]);
                     rsp_in.entry_kind      = f ? KIND_SECOND : KIND_FIRST;
                     rsp_in.bookmark_before = bm_ff;
                     rsp_in.last_entry      = (pos_in[0] >= cnt_ff[0]) &&
                                              (pos_in[1] >= cnt_ff[1]);
                     rsp_in.files_differ    = 1'b1;
                     rsp_in.overflow        = ovf_ff;
                     q_pop                  = 1'b1;
                     st_in                  = ST_IDLE;
                  end
               end else if (!f) begin
                  phase_in = PH_DIFF2;
                  bm_in    = 1'b1;
               end else begin
                  phase_in = PH_DECIDE;
                  bm_in    = 1'b0;
               end
            end else if (rsp_free) begin
               phase_in               = PH_DONE;
               rsp_valid_in           = 1'b1;
               rsp_in.entry_valid     = 1'b0;
               rsp_in.entry_file      = 1'b0;
               rsp_in.entry_line      = '0;
               rsp_in.entry_kind      = KIND_COMMON;
               rsp_in.bookmark_before = 1'b0;
               rsp_in.last_entry      = 1'b1;
               rsp_in.files_differ    = differ_ff;
               rsp_in.overflow        = ovf_ff;
               q_pop                  = 1'b1;
               st_in                  = ST_IDLE;
            end
         end

         ST_CHK_RD: st_in = ST_CHK_CMP;

         // current lines agree: common entry, else resync
         ST_CHK_CMP: begin
            if (rd0 == rd1) begin
               if (rsp_free) begin
                  pos_in[0]              = pos_ff[0] + 1'b1;
                  pos_in[1]              = pos_ff[1] + 1'b1;
                  rsp_valid_in           = 1'b1;
                  rsp_in.entry_valid     = 1'b1;
                  rsp_in.entry_file      = 1'b0;
                  rsp_in.entry_line      = LINE_W'(pos_ff[0]);
                  rsp_in.entry_kind      = KIND_COMMON;
                  rsp_in.bookmark_before = 1'b0;
                  rsp_in.last_entry      = (pos_in[0] >= cnt_ff[0]) &&
                                           (pos_in[1] >= cnt_ff[1]);
                  rsp_in.files_differ    = differ_ff;
                  rsp_in.overflow        = ovf_ff;
                  q_pop                  = 1'b1;
                  st_in                  = ST_IDLE;
               end
            end else begin
               outer_in = 1'b0;
               st_in    = ST_S_INIT;
            end
         end

         ST_S_INIT: begin
            j_in    = pos_ff[outer_ff];
            stop_in = cnt_ff[outer_ff];
            best_in = '0;
            at1_in  = '0;
            at2_in  = '0;
            st_in   = ST_S_J;
         end

         ST_S_J: begin
            if (j_ff < cnt_ff[outer_ff] && j_ff < stop_ff) begin
               i_in  = pos_ff[inner];
               st_in = ST_S_I;
            end else begin
               st_in = ST_S_END;
            end
         end

         ST_S_I: begin
            if (i_ff < cnt_ff[inner] && i_ff < stop_ff) begin
               rl_a_in = outer_ff ? i_ff : j_ff;
               rl_b_in = outer_ff ? j_ff : i_ff;
               rl_m_in = '0;
               st_in   = ST_RL_RD;
            end else begin
               st_in = ST_S_NEXTJ;
            end
         end

         // run length walk: each line pair is read, then compared
         ST_RL_RD: begin
            if (rl_a_ff < cnt_ff[0] && rl_b_ff < cnt_ff[1]) begin
               st_in = ST_RL_CMP;
            end else begin
               st_in = ST_RL_DONE;
            end
         end

         ST_RL_CMP: begin
            if (rd0 == rd1) begin
               rl_m_in = rl_m_ff + 1'b1;
               rl_a_in = rl_a_ff + 1'b1;
               rl_b_in = rl_b_ff + 1'b1;
               st_in   = ST_RL_RD;
            end else begin
               st_in = ST_RL_DONE;
            end
         end

         ST_RL_DONE: begin
            if (rl_m_ff != '0) begin
               if (rl_m_ff > best_ff) begin
                  best_in = rl_m_ff;
                  at1_in  = outer_ff ? i_ff : j_ff;
                  at2_in  = outer_ff ? j_ff : i_ff;
                  if (hi_sum < {1'b0, stop_ff}) begin
                     stop_in = CW'(hi_sum);
                  end
               end
               st_in = ST_S_NEXTJ;
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = ST_S_I;
            end
         end

         ST_S_NEXTJ: begin
            if (jb_sum >= {1'b0, stop_ff}) begin
               st_in = ST_S_END;
            end else begin
               j_in  = j_ff + 1'b1;
               st_in = ST_S_J;
            end
         end

         // keep first search result, or pick the winner
         ST_S_END: begin
            if (!outer_ff) begin
               m1_in    = best_ff;
               s1_in    = at1_ff;
               s2_in    = at2_ff;
               outer_in = 1'b1;
               st_in    = ST_S_INIT;
            end else begin
               if (m1_ff != '0 && m1_ff >= best_ff) begin
                  tgt_in[0] = s1_ff;
                  tgt_in[1] = s2_ff;
               end else if (best_ff != '0) begin
                  tgt_in[0] = at1_ff;
                  tgt_in[1] = at2_ff;
               end else begin
                  tgt_in = cnt_ff;
               end
               phase_in = PH_DIFF1;
               bm_in    = 1'b1;
               st_in    = ST_STEP;
            end
         end

         default: st_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         phase_ff     <= PH_LOADING;
         hash_ff[0]   <= HASH_SEED;
         hash_ff[1]   <= HASH_SEED;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         tgt_ff[0]    <= '0;
         tgt_ff[1]    <= '0;
         differ_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         bm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         hash_ff      <= hash_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         tgt_ff       <= tgt_in;
         differ_ff    <= differ_in;
         ovf_ff       <= ovf_in;
         bm_ff        <= bm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      outer_ff <= outer_in;
      j_ff     <= j_in;
      i_ff     <= i_in;
      stop_ff  <= stop_in;
      best_ff  <= best_in;
      at1_ff   <= at1_in;
      at2_ff   <= at2_in;
      m1_ff    <= m1_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      rl_a_ff  <= rl_a_in;
      rl_b_ff  <= rl_b_in;
      rl_m_ff  <= rl_m_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[hw/rtl/line_hash_diff_engine.sv]
// ---------------------------------------------------------------------------
// line_hash_diff_engine
// Loads two texts, hashes each line and hands out a merged diff listing
// one entry per fetch.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_stall | command, file_select, char_byte
//  rsp_     | out       | rsp_valid/rsp_stall | entry fields and sticky flags
//  csr_     | in        | csr_wr_en           | skip_whitespace
//
//  Push, end-of-line and clear are each handled straight from the idle
//  state; a four-entry request queue accepts while the engine is busy.
//  A fetch that lands on agreeing lines passes dispatch, decide, memory
//  read and compare; one inside a difference run passes dispatch and the
//  emitting step, plus a further step per phase change on the way.
//  A resync walks the hash memories, reading then comparing each line
//  pair, bounded by the search loops, per search.
//  Reset is synchronous; no clearing pass, hash memories hold garbage until
//  written. The response register holds under rsp_stall.
// ---------------------------------------------------------------------------
module line_hash_diff_engine
   import lhd_pkg::*;
#(
   parameter int unsigned MAX_LINES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_file_select,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_entry_valid,
   output logic        rsp_entry_file,
   output logic [9:0]  rsp_entry_line,
   output logic [1:0]  rsp_entry_kind,
   output logic        rsp_bookmark_before,
   output logic        rsp_last_entry,
   output logic        rsp_files_differ,
   output logic        rsp_overflow,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic         skip_ws_ff;
   logic         q_valid;
   logic         q_pop;
   req_item_type q_item;
   rsp_item_type rsp_item;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ws_ff <= 1'b0;
      end else if (csr_wr_en) begin
         skip_ws_ff <= csr_wr_data;
      end
   end

   lhd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_file_select (req_file_select),
      .req_char_byte   (req_char_byte),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   lhd_engine #(.MAX_LINES(MAX_LINES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .skip_ws   (skip_ws_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_entry_valid     = rsp_item.entry_valid;
   assign rsp_entry_file      = rsp_item.entry_file;
   assign rsp_entry_line      = rsp_item.entry_line;
   assign rsp_entry_kind      = rsp_item.entry_kind;
   assign rsp_bookmark_before = rsp_item.bookmark_before;
   assign rsp_last_entry      = rsp_item.last_entry;
   assign rsp_files_differ    = rsp_item.files_differ;
   assign rsp_overflow        = rsp_item.overflow;

   // checks
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_kind != 2'd3)
      else $error("illegal entry kind");

   a_null_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_last_entry)
      else $error("null entry not marked last");

   a_common_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid && rsp_entry_kind == KIND_COMMON
      |-> !rsp_entry_file && !rsp_bookmark_before)
      else $error("common entry from wrong text");

   a_bookmark_differ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bookmark_before |-> rsp_files_differ)
      else $error("bookmark without difference flag");

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Checks the line hash diff engine against a cycle-free predictor of the
// merge. Runs directed jobs, whitespace skipping, capacity overflow, back
// pressure and random jobs with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench;
   import lhd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINES_CAP = 1024;

   typedef enum logic [2:0] {
      MP_LOADING, MP_DECIDE, MP_DIFF_FIRST, MP_DIFF_SECOND, MP_DONE
   } merge_phase_type;

   typedef bit [7:0] text_line_type[$];

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_command;
   logic       req_file_select;
   logic [7:0] req_char_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_entry_valid;
   logic       rsp_entry_file;
   logic [9:0] rsp_entry_line;
   logic [1:0] rsp_entry_kind;
   logic       rsp_bookmark_before;
   logic       rsp_last_entry;
   logic       rsp_files_differ;
   logic       rsp_overflow;
   logic       csr_wr_en;
   logic       csr_wr_data;

   line_hash_diff_engine #(.MAX_LINES(LINES_CAP)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_file_select(req_file_select),
      .req_char_byte(req_char_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_entry_valid(rsp_entry_valid), .rsp_entry_file(rsp_entry_file),
      .rsp_entry_line(rsp_entry_line), .rsp_entry_kind(rsp_entry_kind),
      .rsp_bookmark_before(rsp_bookmark_before), .rsp_last_entry(rsp_last_entry),
      .rsp_files_differ(rsp_files_differ), .rsp_overflow(rsp_overflow),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // predictor state
   bit [31:0]       line_hash[2][LINES_CAP];
   bit [31:0]       cur_hash[2];
   int unsigned     n_lines[2];
   int unsigned     merge_pos[2];
   int unsigned     resync_at[2];
   merge_phase_type mphase;
   bit              fl_differ, fl_overflow, fl_bookmark;
   bit              skip_ws;

   rsp_item_type    merged_entries_q[$];
   int              error_count;
   int              sent_count;
   bit              idle_en;
   int              stall_hold;
   int              stall_burst;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // --- predictor -----------------------------------------------------------
   function automatic void clear_job();
      cur_hash[0] = HASH_SEED;
      cur_hash[1] = HASH_SEED;
      n_lines = '{0, 0};
      merge_pos = '{0, 0};
      resync_at = '{0, 0};
      mphase = MP_LOADING;
      fl_differ = 0;
      fl_overflow = 0;
      fl_bookmark = 0;
   endfunction

   function automatic int unsigned match_len(int unsigned a, int unsigned b);
      int unsigned n;
      n = 0;
      while (a < n_lines[0] && b < n_lines[1] && line_hash[0][a] == line_hash[1][b]) begin
         n++;
         a++;
         b++;
      end
      return n;
   endfunction

   // greedy search: outer walks one text, inner the other
   function automatic int unsigned greedy_search(bit outer, output int unsigned at0,
                                                 output int unsigned at1);
      bit          inner;
      int unsigned stop, best, j, i, m, hi;
      inner = ~outer;
      stop = n_lines[outer];
      best = 0;
      at0 = 0;
      at1 = 0;
      for (j = merge_pos[outer]; j < n_lines[outer] && j < stop; j++) begin
         for (i = merge_pos[inner]; i < n_lines[inner] && i < stop; i++) begin
            m = (outer == 0) ? match_len(j, i) : match_len(i, j);
            if (m != 0) begin
               if (m > best) begin
                  best = m;
                  at0 = (outer == 0) ? j : i;
                  at1 = (outer == 0) ? i : j;
                  hi = (i > j) ? i : j;
                  if (hi + m < stop) stop = hi + m;
               end
               break;
            end
         end
         if (j + best >= stop) break;
      end
      return best;
   endfunction

   function automatic void pick_resync();
      int unsigned a0, a1, b0, b1, m1, m2;
      m1 = greedy_search(0, a0, a1);
      m2 = greedy_search(1, b0, b1);
      if (m1 != 0 && m1 >= m2) begin
         resync_at = '{a0, a1};
      end else if (m2 != 0) begin
         resync_at = '{b0, b1};
      end else begin
         resync_at = '{n_lines[0], n_lines[1]};
      end
   endfunction

   function automatic rsp_item_type make_entry(bit f, int unsigned line, logic [1:0] kind,
                                               bit bm);
      rsp_item_type e;
      e.entry_valid = 1;
      e.entry_file = f;
      e.entry_line = line[LINE_W-1:0];
      e.entry_kind = kind;
      e.bookmark_before = bm;
      e.last_entry = merge_pos[0] >= n_lines[0] && merge_pos[1] >= n_lines[1];
      e.files_differ = fl_differ;
      e.overflow = fl_overflow;
      return e;
   endfunction

   function automatic rsp_item_type next_entry();
      rsp_item_type e;
      int unsigned  p;
      bit           f, bm;
      if (mphase == MP_LOADING) mphase = MP_DECIDE;
      forever begin
         if (mphase == MP_DECIDE) begin
            if (merge_pos[0] >= n_lines[0] && merge_pos[1] >= n_lines[1]) begin
               mphase = MP_DONE;
            end else if (merge_pos[0] >= n_lines[0] || merge_pos[1] >= n_lines[1]) begin
               resync_at = '{n_lines[0], n_lines[1]};
               mphase = MP_DIFF_FIRST;
               fl_bookmark = 1;
            end else if (match_len(merge_pos[0], merge_pos[1]) != 0) begin
               p = merge_pos[0];
               merge_pos[0]++;
               merge_pos[1]++;
               return make_entry(0, p, KIND_COMMON, 0);
            end else begin
               pick_resync();
               mphase = MP_DIFF_FIRST;
               fl_bookmark = 1;
            end
         end else if (mphase == MP_DIFF_FIRST || mphase == MP_DIFF_SECOND) begin
            f = (mphase == MP_DIFF_SECOND);
            p = merge_pos[f];
            if (p < resync_at[f]) begin
               bm = fl_bookmark;
               fl_bookmark = 0;
               fl_differ = 1;
               merge_pos[f] = p + 1;
               return make_entry(f, p, f ? KIND_SECOND : KIND_FIRST, bm);
            end
            if (!f) begin
               mphase = MP_DIFF_SECOND;
               fl_bookmark = 1;
            end else begin
               mphase = MP_DECIDE;
               fl_bookmark = 0;
            end
         end else begin
            e = '0;
            e.last_entry = 1;
            e.files_differ = fl_differ;
            e.overflow = fl_overflow;
            return e;
         end
      end
   endfunction

   function automatic void predict_req(cmd_type c, bit f, bit [7:0] b);
      case (c)
         CMD_CLEAR: clear_job();
         CMD_FETCH: merged_entries_q.push_back(next_entry());
         CMD_PUSH: begin
            if (mphase == MP_LOADING && !(skip_ws && b <= WS_LIMIT))
               cur_hash[f] = cur_hash[f] * 33 + b;
         end
         default: begin
            if (mphase == MP_LOADING) begin
               if (n_lines[f] < LINES_CAP) begin
                  line_hash[f][n_lines[f]] = cur_hash[f];
                  n_lines[f]++;
               end else begin
                  fl_overflow = 1;
               end
               cur_hash[f] = HASH_SEED;
            end
         end
      endcase
   endfunction

   // --- request side ----------------------------------------------------------
   task automatic send_req(cmd_type c, bit f = 0, bit [7:0] b = 0);
      int gap;
      gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= c;
      req_file_select <= f;
      req_char_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_req(c, f, b);
      sent_count++;
   endtask

   task automatic send_line(bit f, text_line_type ln);
      foreach (ln[k]) send_req(CMD_PUSH, f, ln[k]);
      send_req(CMD_EOL, f);
   endtask

   task automatic fetch_n(int n);
      repeat (n) send_req(CMD_FETCH);
   endtask

   // sender pauses until every pending entry is back and the engine is quiet
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (merged_entries_q.size() == 0);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_skip_ws(bit v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      skip_ws = v;
   endtask

   // --- response side ---------------------------------------------------------
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_burst <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(string nm, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $realtime, nm, want, got);
         error_count++;
      end
   endfunction

   // compare each transfer with the oldest predicted entry
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (merged_entries_q.size() == 0) begin
            $display("%0t: unexpected entry, expected none actual line %0d",
                     $realtime, rsp_entry_line);
            error_count++;
         end else begin
            want = merged_entries_q.pop_front();
            check_field("entry_valid", want.entry_valid, rsp_entry_valid);
            check_field("entry_file", want.entry_file, rsp_entry_file);
            check_field("entry_line", want.entry_line, rsp_entry_line);
            check_field("entry_kind", want.entry_kind, rsp_entry_kind);
            check_field("bookmark_before", want.bookmark_before, rsp_bookmark_before);
            check_field("last_entry", want.last_entry, rsp_last_entry);
            check_field("files_differ", want.files_differ, rsp_files_differ);
            check_field("overflow", want.overflow, rsp_overflow);
         end
      end
   end

   // --- tests -----------------------------------------------------------------
   task automatic test_directed();
      // common, first-only and second-only lines, byte extremes
      send_line(0, '{8'h00, 8'hff});
      send_line(0, '{8'h41});
      send_line(1, '{8'h00, 8'hff});
      send_line(1, '{8'h42});
      send_req(CMD_PUSH, 1, 8'h7e);   // unfinished line is dropped
      fetch_n(3);
      send_req(CMD_PUSH, 0, 8'h55);   // ignored once merging began
      send_req(CMD_EOL, 0);
      fetch_n(3);                     // fetches past the end
      // two empty texts
      send_req(CMD_CLEAR);
      fetch_n(2);
      // one empty text goes straight to the tails
      send_req(CMD_CLEAR);
      send_line(0, '{8'h31});
      send_line(0, '{8'h32});
      fetch_n(3);
      send_req(CMD_CLEAR);
   endtask

   task automatic test_skip_whitespace();
      set_skip_ws(1);
      send_line(0, '{8'h20, 8'h61, 8'h09});
      send_line(1, '{8'h61, 8'h21});
      send_line(1, '{8'h00, 8'h61, 8'h20});
      fetch_n(4);
      send_req(CMD_CLEAR);
      set_skip_ws(0);
   endtask

   task automatic test_overflow();
      repeat (LINES_CAP + 2) send_req(CMD_EOL, 1);
      send_line(0, '{8'h10});
      fetch_n(4);
      send_req(CMD_CLEAR);
      wait_drained();
   endtask

   // random job: second text is an edited copy of the first
   task automatic run_job(int max_lines);
      text_line_type pool[4];
      int            t0[$], t1[$];
      int            n0, k, nf;
      bit            f;
      foreach (pool[p]) begin
         repeat ($urandom_range(0, 3)) pool[p].push_back($urandom_range(0, 3) == 0 ?
            8'h20 : 8'($urandom_range(0, 255)));
      end
      n0 = $urandom_range(0, max_lines);
      repeat (n0) t0.push_back($urandom_range(0, 3));
      foreach (t0[i]) begin
         k = $urandom_range(0, 5);
         if (k == 0) t1.push_back($urandom_range(0, 3));
         if (k != 1) t1.push_back(t0[i]);
         if (k == 2) t1.push_back($urandom_range(0, 3));
      end
      // interleave the two loads
      while (t0.size() + t1.size() > 0) begin
         f = (t0.size() == 0) || (t1.size() != 0 && $urandom_range(0, 1));
         if ($urandom_range(0, 19) == 0) send_req(cmd_type'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         if (f) send_line(1, pool[t1.pop_front()]);
         else send_line(0, pool[t0.pop_front()]);
      end
      nf = int'(n_lines[0] + n_lines[1] + $urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) nf = $urandom_range(1, nf);
      fetch_n(nf);
      if ($urandom_range(0, 9) == 0) send_req(cmd_type'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      send_req(CMD_CLEAR);
   endtask

   // receiver holds off while fetches keep coming, so the queue fills up
   task automatic test_backpressure();
      bit [7:0] ch;
      ch = 8'h30;
      repeat (6) begin
         send_line(0, '{ch});
         send_line(1, '{ch});
         ch++;
      end
      stall_hold = 400;
      fetch_n(14);
      send_req(CMD_CLEAR);
      wait_drained();
   endtask

   task automatic test_random();
      while (sent_count < 1550) begin
         if ($urandom_range(0, 5) == 0) set_skip_ws(1'($urandom_range(0, 1)));
         if (sent_count > 1350) idle_en = 0;
         run_job($urandom_range(0, 9) == 0 ? 24 : 10);
      end
   endtask

   // --- sequence ------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_PUSH;
      req_file_select = 1'b0;
      req_char_byte = 8'h00;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      error_count = 0;
      sent_count = 0;
      idle_en = 1;
      stall_hold = 0;
      stall_burst = 0;
      skip_ws = 0;
      clear_job();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_skip_whitespace();
      test_overflow();
      test_backpressure();
      test_random();

      wait_drained();
      repeat (100) @(negedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/lhd_pkg.sv
hw/rtl/lhd_ram.sv
hw/rtl/lhd_front.sv
hw/rtl/lhd_engine.sv
hw/rtl/line_hash_diff_engine.sv
tb/sv/testbench.sv
